// ===== design/fkscan_pkg.sv =====
// Shared types and constants for the four-key scanner.
// Used by fkscan_ctrl, fkscan_dp and four_key_click_long_repeat_scanner_core.
`default_nettype none
package fkscan_pkg;

  typedef logic [2:0] event_t;

  localparam event_t EV_NONE        = 3'd0;
  localparam event_t EV_ENTER_LONG  = 3'd5;
  localparam event_t EV_UP_REPEAT   = 3'd6;
  localparam event_t EV_DOWN_REPEAT = 3'd7;

  localparam logic [1:0] KEY_UP    = 2'd0;
  localparam logic [1:0] KEY_DOWN  = 2'd1;
  localparam logic [1:0] KEY_ENTER = 2'd2;
  localparam logic [1:0] KEY_BACK  = 2'd3;

  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_LONG     = 2'd1;
  localparam logic [1:0] CFG_DELAY    = 2'd2;
  localparam logic [1:0] CFG_PERIOD   = 2'd3;

  localparam logic [7:0]  DEBOUNCE_RESET = 8'd3;
  localparam logic [15:0] LONG_RESET     = 16'd80;
  localparam logic [15:0] DELAY_RESET    = 16'd40;
  localparam logic [7:0]  PERIOD_RESET   = 8'd5;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_LOCKED   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_MOD  = 2'd2,
    ST_DONE = 2'd3
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic mod_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic stop;
    logic need_mod;
    logic last_key;
    logic mod_last;
    logic mod_zero;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== design/fkscan_ctrl.sv =====
// Controller state machine of the four-key scanner.
// Depends on fkscan_pkg; drives commands to fkscan_dp.
`default_nettype none
module fkscan_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  fkscan_pkg::status_t status_i,
  output fkscan_pkg::cmd_t    cmd_o
);

  fkscan_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fkscan_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fkscan_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = fkscan_pkg::ST_SCAN;
      end
      fkscan_pkg::ST_SCAN: begin
        if (status_i.stop) state_d = fkscan_pkg::ST_DONE;
        else if (status_i.need_mod) state_d = fkscan_pkg::ST_MOD;
        else if (status_i.last_key) state_d = fkscan_pkg::ST_DONE;
      end
      fkscan_pkg::ST_MOD: begin
        if (status_i.mod_last) begin
          if (status_i.mod_zero || status_i.last_key) state_d = fkscan_pkg::ST_DONE;
          else state_d = fkscan_pkg::ST_SCAN;
        end
      end
      fkscan_pkg::ST_DONE: begin
        if (status_i.out_free) state_d = fkscan_pkg::ST_IDLE;
      end
      default: state_d = fkscan_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      fkscan_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      fkscan_pkg::ST_SCAN: cmd_o.step = 1'b1;
      fkscan_pkg::ST_MOD:  cmd_o.mod_step = 1'b1;
      fkscan_pkg::ST_DONE: cmd_o.emit = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  a_load_to_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == fkscan_pkg::ST_SCAN)
    else $error("A loaded beat did not start the scan.");

  a_mod_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fkscan_pkg::ST_MOD && $past(state_q) != fkscan_pkg::ST_MOD)
      |-> $past(state_q) == fkscan_pkg::ST_SCAN && $past(status_i.need_mod))
    else $error("The remainder unit started without a repeat check.");

endmodule
`default_nettype wire

// ===== design/fkscan_dp.sv =====
// Datapath of the four-key scanner: settings, key phases and hold counters,
// the serial remainder unit and the output register. Depends on fkscan_pkg.
`default_nettype none
module fkscan_dp (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [1:0]          cfg_idx_i,
  input  wire  [15:0]         cfg_data_i,
  input  wire  [3:0]          levels_i,
  input  fkscan_pkg::cmd_t    cmd_i,
  output fkscan_pkg::status_t status_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output fkscan_pkg::event_t  key_event_o
);

  logic [7:0]  debounce_q;
  logic [15:0] long_q;
  logic [15:0] delay_q;
  logic [7:0]  period_q;

  fkscan_pkg::phase_e phase_q [4];
  logic [15:0]        count_q [4];

  logic [3:0]          levels_q;
  logic [1:0]          key_q;
  fkscan_pkg::event_t  event_q;
  logic [15:0]         div_q;
  logic [7:0]          rem_q;
  logic [3:0]          mod_cnt_q;
  logic                out_valid_q;
  fkscan_pkg::event_t  key_event_q;

  logic               pressed;
  fkscan_pkg::phase_e cur_phase;
  logic [15:0]        cur_count;
  logic [15:0]        count_inc;
  logic               stop;
  logic               need_mod;
  logic [7:0]         period_eff;
  logic [8:0]         trial;
  logic [7:0]         rem_next;
  logic               mod_last;
  logic               mod_zero;

  assign cur_phase  = phase_q[key_q];
  assign cur_count  = count_q[key_q];
  assign pressed    = ~levels_q[key_q];
  assign count_inc  = cur_count + 16'd1;
  assign period_eff = (period_q == 8'd0) ? 8'd1 : period_q;

  always_comb begin
    stop     = 1'b0;
    need_mod = 1'b0;
    if (pressed && cur_phase == fkscan_pkg::PH_PRESSED) begin
      if (key_q == fkscan_pkg::KEY_ENTER) begin
        stop = count_inc >= long_q;
      end else if (key_q == fkscan_pkg::KEY_UP || key_q == fkscan_pkg::KEY_DOWN) begin
        need_mod = count_inc >= delay_q;
      end
    end
  end

  assign trial    = {rem_q, div_q[15]};
  assign rem_next = (trial >= {1'b0, period_eff}) ? 8'(trial - {1'b0, period_eff})
                                                   : trial[7:0];
  assign mod_last = mod_cnt_q == 4'd15;
  assign mod_zero = rem_next == 8'd0;

  assign status_o.stop     = stop;
  assign status_o.need_mod = need_mod;
  assign status_o.last_key = key_q == fkscan_pkg::KEY_BACK;
  assign status_o.mod_last = mod_last;
  assign status_o.mod_zero = mod_zero;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= fkscan_pkg::DEBOUNCE_RESET;
      long_q     <= fkscan_pkg::LONG_RESET;
      delay_q    <= fkscan_pkg::DELAY_RESET;
      period_q   <= fkscan_pkg::PERIOD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fkscan_pkg::CFG_DEBOUNCE: debounce_q <= cfg_data_i[7:0];
        fkscan_pkg::CFG_LONG:     long_q     <= cfg_data_i;
        fkscan_pkg::CFG_DELAY:    delay_q    <= cfg_data_i;
        fkscan_pkg::CFG_PERIOD:   period_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        phase_q[i] <= fkscan_pkg::PH_RELEASED;
        count_q[i] <= 16'd0;
      end
      key_q     <= 2'd0;
      event_q   <= fkscan_pkg::EV_NONE;
      mod_cnt_q <= 4'd0;
    end else begin
      if (cmd_i.load) begin
        key_q   <= 2'd0;
        event_q <= fkscan_pkg::EV_NONE;
      end else if (cmd_i.step) begin
        if (pressed) begin
          unique case (cur_phase)
            fkscan_pkg::PH_RELEASED: begin
              count_q[key_q] <= count_inc;
              if (count_inc >= {8'd0, debounce_q}) phase_q[key_q] <= fkscan_pkg::PH_PRESSED;
            end
            fkscan_pkg::PH_PRESSED: begin
              count_q[key_q] <= count_inc;
              if (stop) begin
                phase_q[key_q] <= fkscan_pkg::PH_LOCKED;
                event_q        <= fkscan_pkg::EV_ENTER_LONG;
              end
            end
            default: ;
          endcase
        end else begin
          if (cur_phase == fkscan_pkg::PH_PRESSED) event_q <= {1'b0, key_q} + 3'd1;
          phase_q[key_q] <= fkscan_pkg::PH_RELEASED;
          count_q[key_q] <= 16'd0;
        end
        mod_cnt_q <= 4'd0;
        if (!stop && !need_mod) key_q <= key_q + 2'd1;
      end else if (cmd_i.mod_step) begin
        mod_cnt_q <= mod_cnt_q + 4'd1;
        if (mod_last) begin
          if (mod_zero) begin
            event_q <= (key_q == fkscan_pkg::KEY_UP) ? fkscan_pkg::EV_UP_REPEAT
                                                     : fkscan_pkg::EV_DOWN_REPEAT;
          end else begin
            key_q <= key_q + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) levels_q <= levels_i;
    if (cmd_i.step) begin
      div_q <= count_inc - delay_q;
      rem_q <= 8'd0;
    end else if (cmd_i.mod_step) begin
      div_q <= {div_q[14:0], 1'b0};
      rem_q <= rem_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) key_event_q <= event_q;
  end

  assign out_valid_o = out_valid_q;
  assign key_event_o = key_event_q;

  a_rem_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mod_step |-> rem_q < period_eff)
    else $error("Partial remainder reached the repeat period.");

  a_long_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && event_q == fkscan_pkg::EV_ENTER_LONG)
      |-> phase_q[fkscan_pkg::KEY_ENTER] == fkscan_pkg::PH_LOCKED)
    else $error("Long press reported without locking the enter key.");

endmodule
`default_nettype wire

// ===== design/four_key_click_long_repeat_scanner_core.sv =====
// Four-key scanner with debounce, click, long press and auto repeat.
// Each accepted input beat is one scan tick and yields exactly one output beat
// with key_event_o (0 when nothing happened). Keys are visited one per cycle in
// the order up, down, enter, back, except while an up or down key that has
// reached its repeat delay runs a bit-serial remainder of its 16-bit hold count
// past the delay against the repeat period. The next beat is taken once the
// result has been placed in the output register. Settings are to be written
// through cfg_we_i / cfg_idx_i / cfg_data_i only while the block is idle; the
// user is bound by this, as the block itself does not enforce it.
// Depends on fkscan_pkg, fkscan_ctrl and fkscan_dp.
`default_nettype none
module four_key_click_long_repeat_scanner_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [15:0] cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         up_level_i,
  input  wire         down_level_i,
  input  wire         enter_level_i,
  input  wire         back_level_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [2:0]  key_event_o
);

  fkscan_pkg::cmd_t    cmd;
  fkscan_pkg::status_t status;

  fkscan_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fkscan_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .levels_i    ({back_level_i, enter_level_i, down_level_i, up_level_i}),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .key_event_o (key_event_o)
  );

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for four_key_click_long_repeat_scanner_core.
// A scoreboard class predicts one key_event per scan tick from its own scanner state.
// Depends on fkscan_pkg and the core; random bursts of idling on both channels.
`default_nettype none
module testbench;

  localparam fkscan_pkg::event_t EV_UP_CLICK    = 3'd1;
  localparam fkscan_pkg::event_t EV_DOWN_CLICK  = 3'd2;
  localparam fkscan_pkg::event_t EV_ENTER_CLICK = 3'd3;
  localparam fkscan_pkg::event_t EV_BACK_CLICK  = 3'd4;

  localparam logic [3:0] ALL_RELEASED = 4'hF;
  localparam logic [3:0] ALL_PRESSED  = 4'h0;

  class key_event_board;
    logic [7:0]          debounce;
    logic [15:0]         long_thr;
    logic [15:0]         delay_thr;
    logic [7:0]          period;
    fkscan_pkg::phase_e  phase[4];
    logic [15:0]         hold[4];
    fkscan_pkg::event_t  pending[$];
    int                  errors, ticks, n_click, n_long, n_repeat, n_quiet;

    function new();
      debounce  = fkscan_pkg::DEBOUNCE_RESET;
      long_thr  = fkscan_pkg::LONG_RESET;
      delay_thr = fkscan_pkg::DELAY_RESET;
      period    = fkscan_pkg::PERIOD_RESET;
      for (int k = 0; k < 4; k++) begin
        phase[k] = fkscan_pkg::PH_RELEASED;
        hold[k]  = '0;
      end
      errors = 0;
      ticks = 0;
      n_click = 0;
      n_long = 0;
      n_repeat = 0;
      n_quiet = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        fkscan_pkg::CFG_DEBOUNCE: debounce  = data[7:0];
        fkscan_pkg::CFG_LONG:     long_thr  = data;
        fkscan_pkg::CFG_DELAY:    delay_thr = data;
        fkscan_pkg::CFG_PERIOD:   period    = data[7:0];
        default: ;
      endcase
    endfunction

    function fkscan_pkg::event_t click_of(int k);
      case (k)
        fkscan_pkg::KEY_UP:    return EV_UP_CLICK;
        fkscan_pkg::KEY_DOWN:  return EV_DOWN_CLICK;
        fkscan_pkg::KEY_ENTER: return EV_ENTER_CLICK;
        default:               return EV_BACK_CLICK;
      endcase
    endfunction

    // Levels are active low, indexed by key: lv[KEY_UP] is the up pin.
    function void note_tick(logic [3:0] lv);
      fkscan_pkg::event_t ev;
      logic [15:0]        since;
      int unsigned        per;
      ev = fkscan_pkg::EV_NONE;
      for (int k = 0; k < 4; k++) begin
        if (!lv[k]) begin
          if (phase[k] == fkscan_pkg::PH_RELEASED) begin
            hold[k] = hold[k] + 16'd1;
            if (hold[k] >= debounce) phase[k] = fkscan_pkg::PH_PRESSED;
          end else if (phase[k] == fkscan_pkg::PH_PRESSED) begin
            hold[k] = hold[k] + 16'd1;
            if (k == fkscan_pkg::KEY_ENTER) begin
              if (hold[k] >= long_thr) begin
                phase[k] = fkscan_pkg::PH_LOCKED;
                ev = fkscan_pkg::EV_ENTER_LONG;
                break;
              end
            end else if (k != fkscan_pkg::KEY_BACK && hold[k] >= delay_thr) begin
              per = (period == 8'd0) ? 1 : period;
              since = hold[k] - delay_thr;
              if (since % per == 0) begin
                ev = (k == fkscan_pkg::KEY_UP) ? fkscan_pkg::EV_UP_REPEAT
                                               : fkscan_pkg::EV_DOWN_REPEAT;
                break;
              end
            end
          end
        end else begin
          if (phase[k] == fkscan_pkg::PH_PRESSED) ev = click_of(k);
          phase[k] = fkscan_pkg::PH_RELEASED;
          hold[k]  = '0;
        end
      end
      pending.push_back(ev);
      ticks++;
    endfunction

    function void check_event(fkscan_pkg::event_t got);
      fkscan_pkg::event_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: key_event %0d arrived with nothing expected", $time, got);
      end else begin
        want = pending.pop_front();
        case (want)
          fkscan_pkg::EV_NONE:       n_quiet++;
          fkscan_pkg::EV_ENTER_LONG: n_long++;
          fkscan_pkg::EV_UP_REPEAT, fkscan_pkg::EV_DOWN_REPEAT: n_repeat++;
          default:                   n_click++;
        endcase
        if (got !== want) begin
          errors++;
          $display("%0t: key_event mismatch, expected %0d, got %0d", $time, want, got);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = fkscan_pkg::CFG_DEBOUNCE;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        up_level_i = 1'b1;
  logic        down_level_i = 1'b1;
  logic        enter_level_i = 1'b1;
  logic        back_level_i = 1'b1;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  key_event_o;

  key_event_board board;
  bit quiet_tail = 1'b0;
  bit steady_run = 1'b0;
  int n_settings = 0;

  four_key_click_long_repeat_scanner_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .up_level_i    (up_level_i),
    .down_level_i  (down_level_i),
    .enter_level_i (enter_level_i),
    .back_level_i  (back_level_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .key_event_o   (key_event_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_event(key_event_o);
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && rst_ni && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 29) == 0) begin
        repeat ($urandom_range(20, 60)) @(negedge clk_i);
      end
    end
  end

  initial begin
    #60000000;
    $display("four_key_click_long_repeat_scanner_core test failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_tick(input logic [3:0] lv);
    if (!quiet_tail && !steady_run && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    {back_level_i, enter_level_i, down_level_i, up_level_i} <= lv;
    do @(posedge clk_i); while (in_stall_o);
    board.note_tick(lv);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    board.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [7:0] deb, input logic [15:0] lng,
                                input logic [15:0] dly, input logic [7:0] per);
    drain();
    put_reg(fkscan_pkg::CFG_DEBOUNCE, {8'h00, deb});
    put_reg(fkscan_pkg::CFG_LONG, lng);
    put_reg(fkscan_pkg::CFG_DELAY, dly);
    put_reg(fkscan_pkg::CFG_PERIOD, {8'h00, per});
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Random ticks, or a press of some keys held for a random length, then released.
  task automatic run_episode();
    logic [3:0]  held;
    logic [3:0]  lv;
    int unsigned pick, sel, len, per, reach, horizon;
    steady_run = ($urandom_range(0, 3) == 0);
    per = (board.period == 8'd0) ? 1 : board.period;
    reach = board.delay_thr + 3 * per;
    if (board.long_thr > reach) reach = board.long_thr;
    horizon = board.debounce + reach + 6;
    if (horizon > 150) horizon = 150;
    pick = $urandom_range(0, 9);
    if (pick <= 1) begin
      repeat ($urandom_range(1, 6)) send_tick(4'($urandom_range(0, 15)));
    end else begin
      sel = $urandom_range(0, 9);
      if (sel < 5) held = 4'b0001 << $urandom_range(0, 3);
      else if (sel < 8) held = 4'($urandom_range(1, 15));
      else held = 4'hF;
      len = (pick <= 3) ? $urandom_range(1, 3) : $urandom_range(1, horizon);
      for (int i = 0; i < len; i++) begin
        lv = ~held;
        if ($urandom_range(0, 19) == 0) lv[$urandom_range(0, 3)] ^= 1'b1;
        send_tick(lv);
      end
      if ($urandom_range(0, 3) == 0) send_tick(~held | 4'($urandom_range(0, 15)));
      repeat ($urandom_range(1, 3)) send_tick(ALL_RELEASED);
    end
  endtask

  initial begin
    int start;
    board = new();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: a confirmed up press clicks, a too-short down press does not.
    send_tick(ALL_RELEASED);
    repeat (3) send_tick(4'b1110);
    send_tick(ALL_RELEASED);
    repeat (2) send_tick(4'b1101);
    send_tick(ALL_RELEASED);

    // Fast settings: long press, both repeats, then a release where the last click wins.
    apply_settings(8'd1, 16'd2, 16'd1, 8'd2);
    repeat (4) send_tick(ALL_PRESSED);
    send_tick(ALL_RELEASED);
    send_tick(4'b1011);
    send_tick(ALL_RELEASED);

    apply_settings(8'd255, 16'hFFFF, 16'hFFFF, 8'd255);
    repeat (258) send_tick(ALL_PRESSED);
    send_tick(ALL_RELEASED);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: apply_settings(8'd0, 16'd0, 16'd0, 8'd0);
        1: apply_settings(fkscan_pkg::DEBOUNCE_RESET, fkscan_pkg::LONG_RESET,
                          fkscan_pkg::DELAY_RESET, fkscan_pkg::PERIOD_RESET);
        default: apply_settings(8'($urandom_range(0, 6)), 16'($urandom_range(0, 40)),
                                16'($urandom_range(0, 30)), 8'($urandom_range(0, 8)));
      endcase
      start = board.ticks;
      while (board.ticks - start < 220) begin
        if ($urandom_range(0, 40) == 0) drain();
        run_episode();
      end
    end

    // Hold up, down and back back to back while up repeats ahead of the others.
    quiet_tail = 1'b1;
    steady_run = 1'b1;
    apply_settings(8'd1, 16'd20, 16'd4, 8'd3);
    repeat (100) send_tick(4'b0100);
    send_tick(ALL_RELEASED);

    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (board.pending.size() != 0) begin
      board.errors++;
      $display("%0t: %0d expected key events never arrived", $time, board.pending.size());
    end

    $display("Ran %0d scan ticks over %0d register settings, ending with a steady stream.",
             board.ticks, n_settings);
    $display("Checked %0d clicks, %0d long presses, %0d repeats and %0d quiet ticks.",
             board.n_click, board.n_long, board.n_repeat, board.n_quiet);
    if (board.errors == 0) begin
      $display("four_key_click_long_repeat_scanner_core test passed");
    end else begin
      $display("four_key_click_long_repeat_scanner_core test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
